// ----- rtl/core/sfsm_pkg.sv -----
// Shared types, constants and field layout for the serial frame statistics monitor.
package sfsm_pkg;

  // Sliding error window length in items
  localparam int unsigned WINDOW_SIZE = 32;

  // Field widths
  localparam int unsigned ERR_W    = 4;
  localparam int unsigned TS_W     = 32;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned WSUM_W   = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_CHECK_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_BYTE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_BYTE    = 2'd2;

  // Operation codes carried on the input tuser
  localparam logic OP_LINE_ERROR = 1'b0;
  localparam logic OP_FRAME      = 1'b1;

  // Input tdata layout, lowest bit first
  localparam int unsigned IN_ERR_LO   = 0;
  localparam int unsigned IN_TS_LO    = IN_ERR_LO + ERR_W;
  localparam int unsigned IN_LEN_LO   = IN_TS_LO + TS_W;
  localparam int unsigned IN_FIRST_LO = IN_LEN_LO + LEN_W;
  localparam int unsigned IN_LAST_LO  = IN_FIRST_LO + BYTE_W;
  localparam int unsigned IN_USED_W   = IN_LAST_LO + BYTE_W;
  localparam int unsigned IN_DATA_W   = ((IN_USED_W + 7) / 8) * 8;

  // Output tdata layout, lowest bit first
  localparam int unsigned OUT_GOOD_LO   = 0;
  localparam int unsigned OUT_GFR_LO    = OUT_GOOD_LO + 1;
  localparam int unsigned OUT_BFR_LO    = OUT_GFR_LO + CNT_W;
  localparam int unsigned OUT_MIN_LO    = OUT_BFR_LO + CNT_W;
  localparam int unsigned OUT_MAX_LO    = OUT_MIN_LO + CNT_W;
  localparam int unsigned OUT_TOT_LO    = OUT_MAX_LO + CNT_W;
  localparam int unsigned OUT_MEAN_LO   = OUT_TOT_LO + CNT_W;
  localparam int unsigned OUT_WIN_LO    = OUT_MEAN_LO + CNT_W;
  localparam int unsigned OUT_FRM_LO    = OUT_WIN_LO + WSUM_W;
  localparam int unsigned OUT_PAR_LO    = OUT_FRM_LO + CNT_W;
  localparam int unsigned OUT_OVR_LO    = OUT_PAR_LO + CNT_W;
  localparam int unsigned OUT_NOI_LO    = OUT_OVR_LO + CNT_W;
  localparam int unsigned OUT_USED_W    = OUT_NOI_LO + CNT_W;
  localparam int unsigned OUT_DATA_W    = ((OUT_USED_W + 7) / 8) * 8;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CALC = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_LOAD = 4'b1000
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;    // latch an accepted request
    logic calc;       // apply the request to the statistics
    logic div_start;  // launch the mean division
    logic load_mean;  // take the quotient into the mean
    logic load_out;   // copy the statistics into the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_div;   // captured request updates the mean
    logic div_busy;   // divider still iterating
  } status_t;

endpackage

// ----- rtl/core/sfsm_div.sv -----
// Restoring unsigned 32-bit divider, one quotient bit per cycle.
module sfsm_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [sfsm_pkg::CNT_W-1:0] dividend,
  input  logic [sfsm_pkg::CNT_W-1:0] divisor,
  output logic                       busy,
  output logic [sfsm_pkg::CNT_W-1:0] quotient
);
  import sfsm_pkg::*;

  localparam int unsigned STEP_W = $clog2(CNT_W + 1);

  logic [STEP_W-1:0] steps;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  quo;
  logic [CNT_W-1:0]  dvs;
  logic [CNT_W:0]    rem_shift;
  logic [CNT_W:0]    diff;
  logic              neg;

  // Trial subtraction for the current bit
  assign rem_shift = {rem, quo[CNT_W-1]};
  assign diff      = rem_shift - {1'b0, dvs};
  assign neg       = diff[CNT_W];

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (start) begin
      steps <= STEP_W'(CNT_W);
    end else if (steps != '0) begin
      steps <= steps - STEP_W'(1);
    end
  end

  // Remainder and quotient shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (steps != '0) begin
      rem <= neg ? rem_shift[CNT_W-1:0] : diff[CNT_W-1:0];
      quo <= {quo[CNT_W-2:0], ~neg};
    end
  end

  assign busy     = (steps != '0);
  assign quotient = quo;

endmodule

// ----- rtl/core/sfsm_ctrl.sv -----
// Sequencing state machine and output valid flag for the statistics monitor.
module sfsm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  sfsm_pkg::status_t status,
  output sfsm_pkg::cmd_t    cmd
);
  import sfsm_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid;
  logic   out_free;

  assign out_free = !out_valid || m_tready;
  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd.calc = 1'b1;
        if (status.need_div) begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIV;
        end else begin
          state_next = ST_LOAD;
        end
      end
      ST_DIV: begin
        if (!status.div_busy) begin
          cmd.load_mean = 1'b1;
          state_next    = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output valid: set on load, cleared once the result is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ----- rtl/core/sfsm_datapath.sv -----
// Statistics registers, error window, configuration and output register.
module sfsm_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  sfsm_pkg::cmd_t                  cmd,
  output sfsm_pkg::status_t               status,
  input  logic                            cfg_we,
  input  logic [sfsm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sfsm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            operation,
  input  logic [sfsm_pkg::ERR_W-1:0]      line_errors,
  input  logic [sfsm_pkg::TS_W-1:0]       timestamp_us,
  input  logic [sfsm_pkg::LEN_W-1:0]      frame_length,
  input  logic [sfsm_pkg::BYTE_W-1:0]     first_byte,
  input  logic [sfsm_pkg::BYTE_W-1:0]     last_byte,
  output logic                            event_good,
  output logic [sfsm_pkg::CNT_W-1:0]      good_frames,
  output logic [sfsm_pkg::CNT_W-1:0]      bad_frames,
  output logic [sfsm_pkg::CNT_W-1:0]      min_gap,
  output logic [sfsm_pkg::CNT_W-1:0]      max_gap,
  output logic [sfsm_pkg::CNT_W-1:0]      total_gap,
  output logic [sfsm_pkg::CNT_W-1:0]      mean_gap,
  output logic [sfsm_pkg::WSUM_W-1:0]     window_errors,
  output logic [sfsm_pkg::CNT_W-1:0]      framing_errors,
  output logic [sfsm_pkg::CNT_W-1:0]      parity_errors,
  output logic [sfsm_pkg::CNT_W-1:0]      overrun_errors,
  output logic [sfsm_pkg::CNT_W-1:0]      noise_errors
);
  import sfsm_pkg::*;

  // Configuration
  logic              check_enable;
  logic [BYTE_W-1:0] head_byte;
  logic [BYTE_W-1:0] tail_byte;

  // Captured request
  logic              cap_op;
  logic [ERR_W-1:0]  cap_errs;
  logic [TS_W-1:0]   cap_ts;
  logic [LEN_W-1:0]  cap_len;
  logic [BYTE_W-1:0] cap_first;
  logic [BYTE_W-1:0] cap_last;

  // Statistics
  logic [WINDOW_SIZE-1:0] window_bits;
  logic [WSUM_W-1:0]      window_sum;
  logic [TS_W-1:0]        last_time;
  logic [CNT_W-1:0]       good_count;
  logic [CNT_W-1:0]       bad_count;
  logic [CNT_W-1:0]       gap_min;
  logic [CNT_W-1:0]       gap_max;
  logic [CNT_W-1:0]       gap_total;
  logic [CNT_W-1:0]       gap_mean;
  logic [CNT_W-1:0]       err_count [ERR_W];
  logic                   item_good;

  // Update logic
  logic [CNT_W-1:0] gap;
  logic [CNT_W-1:0] gap_total_next;
  logic             frame_good;
  logic             req_good;
  logic             err_bit;
  logic             oldest;
  logic             div_busy;
  logic [CNT_W-1:0] quotient;

  assign gap            = cap_ts - last_time;
  assign gap_total_next = gap_total + gap;
  assign frame_good     = !check_enable ||
                          ((cap_len != '0) && (cap_first == head_byte) &&
                           (cap_last == tail_byte));
  assign req_good       = (cap_op == OP_FRAME) ? frame_good : (cap_errs == '0);
  assign err_bit        = !req_good;
  assign oldest         = window_bits[WINDOW_SIZE-1];

  assign status.need_div = (cap_op == OP_FRAME) && (good_count != '0);
  assign status.div_busy = div_busy;

  // Mean divider: new total over the good count before this frame
  sfsm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (gap_total_next),
    .divisor  (good_count),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      check_enable <= 1'b0;
      head_byte    <= '0;
      tail_byte    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CHECK_ENABLE: check_enable <= cfg_data[0];
        REG_HEAD_BYTE:    head_byte    <= cfg_data[BYTE_W-1:0];
        REG_TAIL_BYTE:    tail_byte    <= cfg_data[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap_op    <= operation;
      cap_errs  <= line_errors;
      cap_ts    <= timestamp_us;
      cap_len   <= frame_length;
      cap_first <= first_byte;
      cap_last  <= last_byte;
    end
  end

  // Error window: shift line, oldest bit leaves at the top
  always_ff @(posedge clk) begin
    if (rst) begin
      window_bits <= '0;
      window_sum  <= '0;
    end else if (cmd.calc) begin
      window_bits <= WINDOW_SIZE'({window_bits, err_bit});
      window_sum  <= window_sum - WSUM_W'(oldest) + WSUM_W'(err_bit);
    end
  end

  // Line error counters, one per bit
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ERR_W; i++) begin
        err_count[i] <= '0;
      end
    end else if (cmd.calc && (cap_op == OP_LINE_ERROR)) begin
      for (int i = 0; i < ERR_W; i++) begin
        if (cap_errs[i]) begin
          err_count[i] <= err_count[i] + CNT_W'(1);
        end
      end
    end
  end

  // Frame statistics
  always_ff @(posedge clk) begin
    if (rst) begin
      last_time  <= '0;
      good_count <= '0;
      bad_count  <= '0;
      gap_min    <= '0;
      gap_max    <= '0;
      gap_total  <= '0;
      gap_mean   <= '0;
    end else begin
      if (cmd.calc && (cap_op == OP_FRAME)) begin
        if (good_count == '0) begin
          // no good frame yet: reset the extremes
          gap_min <= '1;
          gap_max <= '0;
        end else begin
          if (gap > gap_max) gap_max <= gap;
          if (gap < gap_min) gap_min <= gap;
          gap_total <= gap_total_next;
        end
        last_time <= cap_ts;
        if (frame_good) begin
          good_count <= good_count + CNT_W'(1);
        end else begin
          bad_count <= bad_count + CNT_W'(1);
        end
      end
      if (cmd.load_mean) begin
        gap_mean <= quotient;
      end
    end
  end

  // Verdict of the request in flight
  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      item_good <= req_good;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      event_good     <= item_good;
      good_frames    <= good_count;
      bad_frames     <= bad_count;
      min_gap        <= gap_min;
      max_gap        <= gap_max;
      total_gap      <= gap_total;
      mean_gap       <= gap_mean;
      window_errors  <= window_sum;
      framing_errors <= err_count[0];
      parity_errors  <= err_count[1];
      overrun_errors <= err_count[2];
      noise_errors   <= err_count[3];
    end
  end

endmodule

// ----- rtl/core/serial_frame_statistics_monitor.sv -----
// Top level of the serial frame statistics monitor.
//
// Takes line-error reports and received-frame events from a serial receiver
// and returns one result per request carrying the full statistics after the
// update: frame counts, interval minimum, maximum, total and mean, the number
// of errors in a sliding window of the last WINDOW_SIZE requests and the
// per-type line error counts. One request is in work at a time; a result
// waiting in the output register does not block the next request. A line-
// error report, or a frame event before the first good frame, goes from
// the idle state through the calc and load states; any other frame event
// also passes the divide state, where it waits on the mean division, which
// runs a restoring divider one quotient bit per cycle over 32 bits. A
// result held back by the receiver stalls the request in work at its
// output load. The user must write configuration only while idle; the
// block itself does not enforce it.
module serial_frame_statistics_monitor (
  input  logic                               clk,
  input  logic                               rst,
  // configuration
  input  logic                               cfg_we,
  input  logic [sfsm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sfsm_pkg::CFG_DATA_W-1:0]    cfg_data,
  // request stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // line_errors[3:0], timestamp_us[35:4], frame_length[51:36],
  // first_byte[59:52], last_byte[67:60], zero pad
  input  logic [sfsm_pkg::IN_DATA_W-1:0]     s_tdata,
  // operation
  input  logic                               s_tuser,
  // result stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // event_good[0], good_frames[32:1], bad_frames[64:33], min_gap[96:65],
  // max_gap[128:97], total_gap[160:129], mean_gap[192:161],
  // window_errors[200:193], framing_errors[232:201], parity_errors[264:233],
  // overrun_errors[296:265], noise_errors[328:297], zero pad
  output logic [sfsm_pkg::OUT_DATA_W-1:0]    m_tdata
);
  import sfsm_pkg::*;

  cmd_t    cmd;
  status_t status;

  logic              event_good;
  logic [CNT_W-1:0]  good_frames;
  logic [CNT_W-1:0]  bad_frames;
  logic [CNT_W-1:0]  min_gap;
  logic [CNT_W-1:0]  max_gap;
  logic [CNT_W-1:0]  total_gap;
  logic [CNT_W-1:0]  mean_gap;
  logic [WSUM_W-1:0] window_errors;
  logic [CNT_W-1:0]  framing_errors;
  logic [CNT_W-1:0]  parity_errors;
  logic [CNT_W-1:0]  overrun_errors;
  logic [CNT_W-1:0]  noise_errors;

  // Controller
  sfsm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath
  sfsm_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .operation      (s_tuser),
    .line_errors    (s_tdata[IN_ERR_LO +: ERR_W]),
    .timestamp_us   (s_tdata[IN_TS_LO +: TS_W]),
    .frame_length   (s_tdata[IN_LEN_LO +: LEN_W]),
    .first_byte     (s_tdata[IN_FIRST_LO +: BYTE_W]),
    .last_byte      (s_tdata[IN_LAST_LO +: BYTE_W]),
    .event_good     (event_good),
    .good_frames    (good_frames),
    .bad_frames     (bad_frames),
    .min_gap        (min_gap),
    .max_gap        (max_gap),
    .total_gap      (total_gap),
    .mean_gap       (mean_gap),
    .window_errors  (window_errors),
    .framing_errors (framing_errors),
    .parity_errors  (parity_errors),
    .overrun_errors (overrun_errors),
    .noise_errors   (noise_errors)
  );

  // Result packing, lowest field first
  assign m_tdata = OUT_DATA_W'({noise_errors, overrun_errors, parity_errors,
                                framing_errors, window_errors, mean_gap,
                                total_gap, max_gap, min_gap, bad_frames,
                                good_frames, event_good});

endmodule
